@@ rtl/assert_macros.svh @@
// Assertion macros shared by the RTL files.
// Depends on nothing; SYNTH removes the checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define CHK_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("check failed");
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("check failed");
`else
`define CHK_IMPL(label, clk, rst_n, ante, cons)
`define CHK_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/rau_pkg.sv @@
// Package for the rational accumulator: widths, beat types, mode codes.
// Depends on nothing.
package rau_pkg;
	localparam int W = 32;
	localparam int W2 = 2 * W;

	typedef enum logic [2:0] {
		MODE_LOAD   = 3'd0,
		MODE_ADD    = 3'd1,
		MODE_SUB    = 3'd2,
		MODE_MUL    = 3'd3,
		MODE_SWAP   = 3'd4,
		MODE_REDUCE = 3'd5
	} mode_t;

	typedef struct packed {
		logic [2:0]    mode;
		logic [W-1:0]  operand_numerator;
		logic [W-1:0]  operand_denominator;
	} in_beat_t;

	typedef struct packed {
		logic [W-1:0]  result_numerator;
		logic [W-1:0]  result_denominator;
		logic [W-1:0]  common_divisor;
		logic          overflow;
		logic          zero_divisor;
	} out_beat_t;

	// Magnitude divide request / reply between sequencer and divider
	typedef struct packed {
		logic          start;
		logic [W-1:0]  dividend;
		logic [W-1:0]  divisor;
	} div_req_t;

	typedef struct packed {
		logic          done;
		logic [W-1:0]  quotient;
		logic [W-1:0]  remainder;
	} div_rsp_t;

	function automatic logic [W-1:0] magn(input logic [W-1:0] x);
		magn = x[W-1] ? (~x + 1'b1) : x;
	endfunction
endpackage

@@ rtl/rau_div.sv @@
// Unsigned restoring divider, one quotient bit per cycle.
// Depends on rau_pkg and assert_macros.svh.
`include "assert_macros.svh"
module rau_div import rau_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  div_req_t  req,
	output div_rsp_t  rsp
);
	localparam int CW = $clog2(W + 1);

	logic [W-1:0]  rem_q, quo_q, dvs_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q, done_q;
	logic [W:0]    trial;
	logic [W:0]    shifted;

	// Shift one dividend bit in and try a subtract
	always_comb begin
		shifted = {rem_q, quo_q[W-1]};
		trial = shifted - {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= CW'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			if (!trial[W]) begin
				rem_q <= trial[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quotient = quo_q;
	assign rsp.remainder = rem_q;

	`CHK_IMPL(a_done_not_busy, clk, arst_n, done_q, !busy_q)
	`CHK_NEXT(a_start_busy, clk, arst_n, req.start, busy_q)
	`CHK_IMPL(a_cnt_live, clk, arst_n, busy_q, cnt_q != '0)
endmodule

@@ rtl/rational_accumulator_unit_core.sv @@
// Top level of the rational accumulator: sequencer, shared multiplier, shared divider.
// Depends on rau_pkg, rau_div and assert_macros.svh.
//
//  channel  | direction | handshake        | payload
//  in       | into      | in_valid/in_stall | in_beat_t
//  out      | out of    | out_valid/out_stall | out_beat_t
//
// Every beat ends with a Euclid pass for the reported GCD, each Euclid step is one
// pass of the bit-serial divider, and reduce runs Euclid twice plus two divides.
// Reset clears the held value to 0/1 and the sequencer to idle.
// in_stall is high from acceptance until the result beat enters the output register;
// a stalled result beat holds the sequencer in its last state.
`include "assert_macros.svh"
module rational_accumulator_unit_core import rau_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_beat_t  in_data,
	output logic      out_valid,
	input  logic      out_stall,
	output out_beat_t out_data
);
	typedef enum logic [12:0] {
		S_IDLE  = 13'b0000000000001,
		S_MUL   = 13'b0000000000010,
		S_MULW  = 13'b0000000000100,
		S_ADD   = 13'b0000000001000,
		S_RG    = 13'b0000000010000,
		S_RGW   = 13'b0000000100000,
		S_RQN   = 13'b0000001000000,
		S_RQNW  = 13'b0000010000000,
		S_RQD   = 13'b0000100000000,
		S_RQDW  = 13'b0001000000000,
		S_FG    = 13'b0010000000000,
		S_FGW   = 13'b0100000000000,
		S_OUT   = 13'b1000000000000
	} state_t;

	state_t        state_q;
	logic [W-1:0]  n_q, d_q, on_q, od_q;
	logic [2:0]    mode_q;
	logic          ov_q, zd_q;
	logic [1:0]    mstep_q;
	logic [W-1:0]  x_q, y_q;
	logic [W-1:0]  ga_q, gb_q;   // Euclid pair: ga is the divisor side
	logic [W-1:0]  g_q;
	logic          out_valid_q;
	out_beat_t     out_q;
	div_req_t      dreq;
	div_rsp_t      drsp;

	// Shared multiplier operands chosen by the step counter
	logic [W-1:0]  ma, mb;
	logic [W2-1:0] prod;
	logic [W-1:0]  prod_q;
	logic          prod_ov_q;
	logic          mneg;
	logic [W2-1:0] pmag;
	logic          pfit;

	always_comb begin
		ma = n_q;
		mb = od_q;
		case (mstep_q)
			2'd0: begin ma = (mode_q == MODE_MUL) ? n_q : n_q; mb = (mode_q == MODE_MUL) ? on_q : od_q; end
			2'd1: begin ma = on_q; mb = d_q; end
			2'd2: begin ma = d_q; mb = od_q; end
			default: begin ma = d_q; mb = od_q; end
		endcase
		mneg = ma[W-1] ^ mb[W-1];
		pmag = W2'(magn(ma)) * W2'(magn(mb));
		pfit = (pmag[W2-1:W] == '0) && (mneg ? (pmag[W-1:0] <= {1'b1, {(W-1){1'b0}}})
			: !pmag[W-1]);
		prod = mneg ? (~pmag + 1'b1) : pmag;
	end

	// Add/sub with overflow
	logic [W-1:0] sum;
	logic         sum_ov;
	always_comb begin
		if (mode_q == MODE_SUB) begin
			sum = x_q - y_q;
			sum_ov = (x_q[W-1] != y_q[W-1]) && (sum[W-1] != x_q[W-1]);
		end else begin
			sum = x_q + y_q;
			sum_ov = (x_q[W-1] == y_q[W-1]) && (sum[W-1] != x_q[W-1]);
		end
	end

	// Divider requests
	always_comb begin
		dreq.start = 1'b0;
		dreq.dividend = magn(gb_q);
		dreq.divisor = magn(ga_q);
		case (state_q)
			S_RG, S_FG: dreq.start = (ga_q != '0);
			S_RQN: begin
				dreq.start = 1'b1;
				dreq.dividend = magn(n_q);
				dreq.divisor = magn(g_q);
			end
			S_RQD: begin
				dreq.start = 1'b1;
				dreq.dividend = magn(d_q);
				dreq.divisor = magn(g_q);
			end
			default: ;
		endcase
	end

	rau_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	logic [W-1:0] trem, squo;
	logic         qneg, qov;
	always_comb begin
		trem = gb_q[W-1] ? (~drsp.remainder + 1'b1) : drsp.remainder;
		qneg = (state_q == S_RQNW) ? (n_q[W-1] ^ g_q[W-1]) : (d_q[W-1] ^ g_q[W-1]);
		squo = qneg ? (~drsp.quotient + 1'b1) : drsp.quotient;
		qov = !qneg && drsp.quotient[W-1];
	end

	assign in_stall = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			n_q <= '0;
			d_q <= W'(1);
			out_valid_q <= 1'b0;
		end else begin
			// Load a beat from the sequencer, hold a stalled one, drop a taken one
			out_valid_q <= (state_q == S_OUT) || (out_valid_q && out_stall);
			case (state_q)
				S_IDLE: if (in_valid) state_q <= S_MUL;
				S_MUL: begin
					case (mode_q)
						MODE_LOAD: begin
							n_q <= on_q;
							d_q <= od_q;
							state_q <= S_FG;
						end
						MODE_ADD, MODE_SUB, MODE_MUL: state_q <= S_MULW;
						MODE_SWAP: begin
							n_q <= d_q;
							d_q <= n_q;
							state_q <= S_FG;
						end
						MODE_REDUCE: state_q <= S_RG;
						default: state_q <= S_FG;
					endcase
				end
				S_MULW: begin
					if (mode_q == MODE_MUL) begin
						if (mstep_q == 2'd0) state_q <= S_MUL;
						else begin
							n_q <= x_q;
							d_q <= prod_q;
							state_q <= S_FG;
						end
					end else if (mstep_q == 2'd3) begin
						d_q <= prod_q;
						state_q <= S_ADD;
					end else state_q <= S_MUL;
				end
				S_ADD: begin
					n_q <= sum;
					state_q <= S_FG;
				end
				S_RG, S_FG: begin
					if (ga_q == '0) begin
						if (state_q == S_FG) state_q <= S_OUT;
						else if (gb_q == '0) state_q <= S_OUT;
						else state_q <= S_RQN;
					end else state_q <= (state_q == S_RG) ? S_RGW : S_FGW;
				end
				S_RGW: if (drsp.done) state_q <= S_RG;
				S_FGW: if (drsp.done) state_q <= S_FG;
				S_RQN: state_q <= S_RQNW;
				S_RQNW: if (drsp.done) begin
					n_q <= squo;
					state_q <= S_RQD;
				end
				S_RQD: state_q <= S_RQDW;
				S_RQDW: if (drsp.done) begin
					d_q <= squo;
					state_q <= S_FG;
				end
				S_OUT: if (!out_valid_q || !out_stall) begin
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				mode_q <= in_data.mode;
				on_q <= in_data.operand_numerator;
				od_q <= in_data.operand_denominator;
				ov_q <= 1'b0;
				zd_q <= 1'b0;
				mstep_q <= 2'd0;
			end
			S_MUL: begin
				prod_q <= prod[W-1:0];
				prod_ov_q <= !pfit;
				if (mode_q == MODE_REDUCE) begin
					ga_q <= n_q;
					gb_q <= d_q;
				end
				if (mode_q == MODE_LOAD || mode_q == MODE_SWAP || mode_q > MODE_REDUCE) begin
					ga_q <= (mode_q == MODE_LOAD) ? on_q : ((mode_q == MODE_SWAP) ? d_q : n_q);
					gb_q <= (mode_q == MODE_LOAD) ? od_q : ((mode_q == MODE_SWAP) ? n_q : d_q);
				end
			end
			S_MULW: begin
				ov_q <= ov_q | prod_ov_q;
				mstep_q <= (mode_q == MODE_MUL && mstep_q == 2'd0) ? 2'd2 : mstep_q + 2'd1;
				if (mstep_q == 2'd0) x_q <= prod_q;
				if (mstep_q == 2'd1) y_q <= prod_q;
				if (mode_q == MODE_MUL && mstep_q == 2'd2) begin
					ga_q <= x_q;
					gb_q <= prod_q;
				end
				if (mode_q != MODE_MUL && mstep_q == 2'd3) gb_q <= prod_q;
			end
			S_ADD: begin
				ov_q <= ov_q | sum_ov;
				ga_q <= sum;
			end
			S_RG: if (ga_q == '0) begin
				g_q <= gb_q;
				if (gb_q == '0) zd_q <= 1'b1;
			end
			S_RGW, S_FGW: if (drsp.done) begin
				gb_q <= ga_q;
				ga_q <= trem;
			end
			S_RQNW: if (drsp.done) ov_q <= ov_q | qov;
			S_RQDW: if (drsp.done) begin
				ov_q <= ov_q | qov;
				ga_q <= n_q;
				gb_q <= squo;
			end
			// Load the result beat only once the output register is free
			S_OUT: if (!out_valid_q || !out_stall) begin
				out_q.result_numerator <= n_q;
				out_q.result_denominator <= d_q;
				out_q.common_divisor <= gb_q;
				out_q.overflow <= ov_q;
				out_q.zero_divisor <= zd_q;
			end
			default: ;
		endcase
	end

	`CHK_IMPL(a_stall_busy, clk, arst_n, state_q != S_IDLE, in_stall)
	`CHK_IMPL(a_onehot, clk, arst_n, 1'b1, $onehot(state_q))
	`CHK_NEXT(a_out_from_seq, clk, arst_n, $rose(out_valid_q) == 1'b0 && state_q == S_OUT && !out_valid_q, out_valid_q)
endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking bench for rational_accumulator_unit_core: fraction load/add/sub/mul/swap/reduce.
// Depends on rau_pkg and the core RTL; predicts each result beat and compares field by field.
module tb_top;
	import rau_pkg::*;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_stall;
	in_beat_t  in_data;
	logic      out_valid;
	logic      out_stall;
	out_beat_t out_data;

	rational_accumulator_unit_core u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

	// predicted accumulator value and queue of expected result beats
	logic signed [31:0] frac_num;
	logic signed [31:0] frac_den;
	out_beat_t          expected_beats[$];
	int                 fail_count;
	bit                 idle_enable;
	bit                 hold_rx;
	int                 hold_rx_cycles;

	always begin
		clk = 1'b1; #10;
		clk = 1'b0; #10;
	end

	// Euclid with truncating remainder; minimum value rem -1 gives 0
	function automatic logic signed [31:0] euclid_gcd(input logic signed [31:0] a,
			input logic signed [31:0] b);
		logic signed [31:0] t;
		logic [31:0] ma;
		logic [31:0] mb;
		logic [31:0] r;
		while (a != 0) begin
			ma = a[31] ? -a : a;
			mb = b[31] ? -b : b;
			r = mb % ma;
			t = b[31] ? -r : r;
			b = a;
			a = t;
		end
		return b;
	endfunction

	// signed product wrapped to 32 bits, flag when it does not fit
	function automatic logic signed [31:0] frac_mul(input logic signed [31:0] a,
			input logic signed [31:0] b, inout bit ov);
		logic signed [63:0] p;
		p = 64'(a) * 64'(b);
		if (p != 64'(p[31:0]) && p != {{32{p[31]}}, p[31:0]}) ov = 1;
		if (p > 64'sd2147483647 || p < -64'sd2147483648) ov = 1;
		return p[31:0];
	endfunction

	// signed quotient of magnitudes with sign; flags only min/-1 wrap
	function automatic logic signed [31:0] frac_div(input logic signed [31:0] a,
			input logic signed [31:0] g, inout bit ov);
		logic [32:0] ma;
		logic [32:0] mg;
		logic [32:0] q;
		bit neg;
		logic signed [33:0] s;
		ma = a[31] ? -34'(a) : 34'(a);
		mg = g[31] ? -34'(g) : 34'(g);
		q = ma / mg;
		neg = a[31] != g[31];
		s = neg ? -34'(q) : 34'(q);
		if (s > 34'sd2147483647 || s < -34'sd2147483648) ov = 1;
		return s[31:0];
	endfunction

	// advance the predicted value by one beat and queue the expected result
	task automatic predict_fraction(input in_beat_t b);
		out_beat_t e;
		bit ov;
		bit zd;
		logic signed [31:0] on;
		logic signed [31:0] od;
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] g;
		logic signed [32:0] s;
		ov = 0;
		zd = 0;
		on = b.operand_numerator;
		od = b.operand_denominator;
		case (b.mode)
			MODE_LOAD: begin
				frac_num = on;
				frac_den = od;
			end
			MODE_ADD, MODE_SUB: begin
				x = frac_mul(frac_num, od, ov);
				y = frac_mul(on, frac_den, ov);
				s = (b.mode == MODE_SUB) ? 33'(x) - 33'(y) : 33'(x) + 33'(y);
				if (s[32] != s[31]) ov = 1;
				frac_den = frac_mul(frac_den, od, ov);
				frac_num = s[31:0];
			end
			MODE_MUL: begin
				frac_num = frac_mul(frac_num, on, ov);
				frac_den = frac_mul(frac_den, od, ov);
			end
			MODE_SWAP: begin
				x = frac_num;
				frac_num = frac_den;
				frac_den = x;
			end
			MODE_REDUCE: begin
				g = euclid_gcd(frac_num, frac_den);
				if (g == 0) begin
					zd = 1;
				end else begin
					frac_num = frac_div(frac_num, g, ov);
					frac_den = frac_div(frac_den, g, ov);
				end
			end
			default: ;
		endcase
		e.result_numerator = frac_num;
		e.result_denominator = frac_den;
		e.common_divisor = euclid_gcd(frac_num, frac_den);
		e.overflow = ov;
		e.zero_divisor = zd;
		expected_beats.push_back(e);
	endtask

	// send one beat, with optional random gap before it; valid stays up after it
	task automatic send_beat(input logic [2:0] m, input logic [31:0] n, input logic [31:0] d);
		in_beat_t b;
		int gap;
		if (idle_enable && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 10);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		b.mode = m;
		b.operand_numerator = n;
		b.operand_denominator = d;
		in_valid <= 1'b1;
		in_data <= b;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_fraction(b);
	endtask

	// drop valid and wait for every expected beat
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (expected_beats.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 5))
			0: return $urandom_range(0, 40) - 20;
			1: return 32'h8000_0000;
			2: return 32'h7fff_ffff;
			3: return $urandom_range(0, 2000) - 1000;
			4: return $urandom_range(0, 65535) * (($urandom_range(0, 1) != 0) ? 1 : -1);
			default: return $urandom;
		endcase
	endfunction

	task automatic test_directed();
		send_beat(MODE_SWAP, 0, 0);
		send_beat(MODE_REDUCE, 0, 0);
		send_beat(MODE_LOAD, 0, 0);
		send_beat(MODE_REDUCE, 0, 0);
		send_beat(MODE_LOAD, 32'h8000_0000, 32'hffff_ffff);
		send_beat(MODE_REDUCE, 0, 0);
		send_beat(MODE_LOAD, 32'h7fff_ffff, 32'h8000_0000);
		send_beat(MODE_SWAP, 0, 0);
		send_beat(MODE_ADD, 32'h7fff_ffff, 32'h7fff_ffff);
		send_beat(MODE_LOAD, 6, -4);
		send_beat(MODE_ADD, 3, 9);
		send_beat(MODE_SUB, -5, 7);
		send_beat(MODE_MUL, 12, -8);
		send_beat(MODE_REDUCE, 0, 0);
		send_beat(MODE_SUB, 0, 0);
		send_beat(3'd6, 32'hffff_ffff, 32'hffff_ffff);
		send_beat(3'd7, 32'h5555_aaaa, 32'haaaa_5555);
		send_beat(MODE_LOAD, -12, 18);
		send_beat(MODE_REDUCE, 0, 0);
		send_beat(MODE_MUL, 32'h8000_0000, 32'h8000_0000);
		send_beat(MODE_LOAD, 32'h8000_0000, 32'h8000_0000);
		send_beat(MODE_REDUCE, 0, 0);
		wait_drained();
	endtask

	// mostly load-then-arith-then-reduce sequences, some noise
	task automatic test_random(input int count);
		logic [2:0] m;
		for (int i = 0; i < count; i++) begin
			if (i % 6 == 0) m = MODE_LOAD;
			else if (i % 6 == 5) m = MODE_REDUCE;
			else m = 3'($urandom_range(0, 7));
			send_beat(m, rand_word(), rand_word());
		end
	endtask

	// hold the receiver long enough that input backs up
	task automatic test_backpressure();
		hold_rx_cycles = 12000;
		hold_rx = 1'b1;
		for (int i = 0; i < 4; i++) send_beat(3'($urandom_range(0, 5)), rand_word(), rand_word());
		wait_drained();
	endtask

	// receiver stall: a long hold when requested, else random bursts while idle_enable is set
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (hold_rx) begin
			out_stall <= 1'b1;
			if (hold_rx_cycles == 0) begin
				hold_rx <= 1'b0;
				out_stall <= 1'b0;
			end else begin
				hold_rx_cycles <= hold_rx_cycles - 1;
			end
		end else if (idle_enable) begin
			out_stall <= ($urandom_range(0, 4) == 0);
		end else begin
			out_stall <= 1'b0;
		end
	end

	// compare each accepted result beat with the oldest prediction
	always @(posedge clk) begin
		out_beat_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_beats.size() == 0) begin
				$display("%0t: unexpected result beat %h", $time, out_data);
				fail_count++;
			end else begin
				e = expected_beats.pop_front();
				if (out_data.result_numerator !== e.result_numerator) begin
					$display("%0t: numerator exp %0d got %0d", $time,
						$signed(e.result_numerator), $signed(out_data.result_numerator));
					fail_count++;
				end
				if (out_data.result_denominator !== e.result_denominator) begin
					$display("%0t: denominator exp %0d got %0d", $time,
						$signed(e.result_denominator), $signed(out_data.result_denominator));
					fail_count++;
				end
				if (out_data.common_divisor !== e.common_divisor) begin
					$display("%0t: gcd exp %0d got %0d", $time,
						$signed(e.common_divisor), $signed(out_data.common_divisor));
					fail_count++;
				end
				if (out_data.overflow !== e.overflow) begin
					$display("%0t: overflow exp %b got %b", $time, e.overflow,
						out_data.overflow);
					fail_count++;
				end
				if (out_data.zero_divisor !== e.zero_divisor) begin
					$display("%0t: zero_divisor exp %b got %b", $time, e.zero_divisor,
						out_data.zero_divisor);
					fail_count++;
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		fail_count = 0;
		idle_enable = 1'b1;
		hold_rx = 1'b0;
		hold_rx_cycles = 0;
		frac_num = 0;
		frac_den = 1;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_backpressure();
		test_random(250);
		wait_drained();
		idle_enable = 1'b0;
		test_random(90);
		wait_drained();
		repeat (50) @(posedge clk);
		if (fail_count == 0 && expected_beats.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	// overall time limit: reports failure if the run does not finish
	initial begin
		#(64'd200_000_000);
		$display("simulation failed");
		$finish;
	end
endmodule
